/* rtl/core/raa_pkg.sv */
// Shared types and constants for the rectangle area allocator.
// No dependencies; used by raa_seq and rect_area_allocator_core in rtl/core.
package raa_pkg;

    localparam int MAX_FREE_RECTS_DEF = 64;
    localparam int COORD_BITS_DEF     = 16;

    localparam int REQ_W     = 16;          // request width/height
    localparam int RES_W     = REQ_W + 1;   // reserved box edges before clipping
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_START_W = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_H = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_W = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_H = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST    = 3'd4;

    localparam logic [CFG_W-1:0] RST_START_W = 16'd256;
    localparam logic [CFG_W-1:0] RST_START_H = 16'd256;
    localparam logic [CFG_W-1:0] RST_LIMIT_W = 16'd256;
    localparam logic [CFG_W-1:0] RST_LIMIT_H = 16'd256;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOROOM = 2'd1;
    localparam logic [1:0] ST_LOST   = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0] start_w;
        logic [CFG_W-1:0] start_h;
        logic [CFG_W-1:0] limit_w;
        logic [CFG_W-1:0] limit_h;
        logic             fast;
    } t_cfg;

endpackage

/* rtl/core/raa_mem.sv */
// Free-rectangle store: one write port, one read port, registered read data.
// No dependencies.
module raa_mem #(
    parameter int AW = 6,
    parameter int DW = 64
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/core/raa_seq.sv */
// Allocation sequencer: search, growth, split, overlap removal and pruning.
// Depends on raa_pkg and raa_mem.
module raa_seq #(
    parameter int MAX_FREE_RECTS = raa_pkg::MAX_FREE_RECTS_DEF,
    parameter int COORD_BITS     = raa_pkg::COORD_BITS_DEF,
    parameter int CNTW           = $clog2(MAX_FREE_RECTS + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  raa_pkg::t_cfg            i_cfg,
    input  logic                     i_restart,
    input  logic                     i_accept,
    input  logic [raa_pkg::REQ_W-1:0] i_req_w,
    input  logic [raa_pkg::REQ_W-1:0] i_req_h,
    output logic                     o_idle,
    output logic                     o_res_valid,
    input  logic                     i_res_ready,
    output logic [1:0]               o_status,
    output logic [raa_pkg::REQ_W-1:0] o_pos_x,
    output logic [raa_pkg::REQ_W-1:0] o_pos_y,
    output logic [CNTW-1:0]          o_count
);

    localparam int CW = COORD_BITS;
    localparam int RW = raa_pkg::RES_W;
    localparam int AW = $clog2(MAX_FREE_RECTS);
    localparam int EW = 4 * CW;
    localparam logic [RW-1:0]   CMAX = RW'((1 << CW) - 1);
    localparam logic [CNTW-1:0] CMAXN = CNTW'(MAX_FREE_RECTS);

    typedef enum logic [19:0] {
        S_INIT  = 20'h00001, S_IDLE = 20'h00002, S_SRD  = 20'h00004,
        S_SCK   = 20'h00008, S_SMUL = 20'h00010, S_SCMP = 20'h00020,
        S_SEND  = 20'h00040, S_GROW = 20'h00080, S_PLACE = 20'h00100,
        S_FADD  = 20'h00200, S_CRD  = 20'h00400, S_CCK  = 20'h00800,
        S_CADD  = 20'h01000, S_DRD  = 20'h02000, S_DWR  = 20'h04000,
        S_PI    = 20'h08000, S_PIL  = 20'h10000, S_PJ   = 20'h20000,
        S_PJC   = 20'h40000, S_DONE = 20'h80000
    } t_state;

    t_state r_state, r_ret;
    logic [CNTW-1:0] r_cnt, r_i, r_j, r_k, r_best;
    logic            r_found, r_fit, r_gw, r_lost, r_fail;
    logic [2*CW-1:0] r_area, r_best_area;
    logic [CW-1:0]   r_fw, r_fh, r_cw, r_ch, r_res_l, r_res_t;
    logic [RW-1:0]   r_res_r, r_res_b;
    logic [raa_pkg::REQ_W-1:0] r_w, r_h;
    logic [EW-1:0]   r_o;
    logic [1:0]      r_q;

    logic          w_en, dir_we, add_req, can_add;
    logic [AW-1:0] w_addr, dir_addr, rd_addr;
    logic [EW-1:0] w_data, dir_data, add_val, rdata;

    raa_mem #(.AW(AW), .DW(EW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_en),
        .i_waddr (w_addr),
        .i_wdata (w_data),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    function automatic logic [CW-1:0] twice(input logic [CW-1:0] v);
        logic [RW-1:0] d;
        d = RW'(v) << 1;
        return (d > CMAX) ? CMAX[CW-1:0] : d[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] fit_start(input logic [raa_pkg::CFG_W-1:0] v);
        if (v == '0) return CW'(1);
        return (RW'(v) > CMAX) ? CMAX[CW-1:0] : v[CW-1:0];
    endfunction

    // Field views of read data and of the held entry
    logic [CW-1:0] rd_l, rd_t, rd_r, rd_b, o_l, o_t, o_r, o_b;
    assign rd_l = rdata[CW-1:0];
    assign rd_t = rdata[2*CW-1:CW];
    assign rd_r = rdata[3*CW-1:2*CW];
    assign rd_b = rdata[4*CW-1:3*CW];
    assign o_l  = r_o[CW-1:0];
    assign o_t  = r_o[2*CW-1:CW];
    assign o_r  = r_o[3*CW-1:2*CW];
    assign o_b  = r_o[4*CW-1:3*CW];

    // Growth decision against entry 0
    logic          g_wok, g_hok, g_merge;
    logic [CW-1:0] g_nw, g_nh;
    assign g_wok = r_gw && (RW'(r_cw) < RW'(i_cfg.limit_w)) && (RW'(r_cw) != CMAX);
    assign g_hok = !r_gw && (RW'(r_ch) < RW'(i_cfg.limit_h)) && (RW'(r_ch) != CMAX);
    assign g_nw  = twice(r_cw);
    assign g_nh  = twice(r_ch);
    assign g_merge = (r_cnt == CNTW'(1)) && (rd_l == '0) && (rd_t == '0) &&
                     (rd_r == r_cw) && (rd_b == r_ch);

    // Placement in the chosen entry
    logic [RW-1:0] pl_r, pl_b;
    logic          pl_cut;
    assign pl_r   = RW'(rd_l) + RW'(r_w);
    assign pl_b   = RW'(rd_t) + RW'(r_h);
    assign pl_cut = (RW'(rd_b - rd_t) > {r_h, 1'b0}) || (RW'(r_h) >= RW'(r_ch >> 1));

    // Overlap cut and containment tests
    logic       ov, ins_ab, ins_ba;
    logic [3:0] cut_c;
    assign ov = (r_res_r > RW'(rd_l)) && (RW'(r_res_l) < RW'(rd_r)) &&
                (r_res_b > RW'(rd_t)) && (RW'(r_res_t) < RW'(rd_b));
    assign cut_c[0] = r_res_r < RW'(o_r);
    assign cut_c[1] = r_res_l > o_l;
    assign cut_c[2] = r_res_b < RW'(o_b);
    assign cut_c[3] = r_res_t > o_t;
    assign ins_ab = (o_l >= rd_l) && (o_t >= rd_t) && (o_r <= rd_r) && (o_b <= rd_b);
    assign ins_ba = (rd_l >= o_l) && (rd_t >= o_t) && (rd_r <= o_r) && (rd_b <= o_b);

    assign can_add = r_cnt < CMAXN;

    always_comb begin
        dir_we   = 1'b0;
        dir_addr = '0;
        dir_data = '0;
        add_req  = 1'b0;
        add_val  = '0;
        rd_addr  = '0;
        unique case (r_state)
            S_INIT: begin
                dir_we   = 1'b1;
                dir_data = {fit_start(i_cfg.start_h), fit_start(i_cfg.start_w),
                            {CW{1'b0}}, {CW{1'b0}}};
            end
            S_SRD:  rd_addr = r_i[AW-1:0];
            S_SEND: rd_addr = r_found ? r_best[AW-1:0] : '0;
            S_GROW: begin
                if (g_wok) begin
                    if (g_merge) begin
                        dir_we   = 1'b1;
                        dir_data = {rd_b, g_nw, rd_t, rd_l};
                    end else begin
                        add_req = 1'b1;
                        add_val = {r_ch, g_nw, {CW{1'b0}}, r_cw};
                    end
                end else if (g_hok) begin
                    if (g_merge) begin
                        dir_we   = 1'b1;
                        dir_data = {g_nh, rd_r, rd_t, rd_l};
                    end else begin
                        add_req = 1'b1;
                        add_val = {g_nh, r_cw, r_ch, {CW{1'b0}}};
                    end
                end
            end
            S_PLACE: begin
                if (i_cfg.fast) begin
                    dir_we   = 1'b1;
                    dir_addr = r_best[AW-1:0];
                    dir_data = {pl_cut ? pl_b[CW-1:0] : rd_b, rd_r, rd_t, pl_r[CW-1:0]};
                end
            end
            S_FADD: begin
                add_req = 1'b1;
                add_val = {o_b, o_r, r_res_b[CW-1:0], r_res_l};
            end
            S_CRD: rd_addr = r_i[AW-1:0];
            S_CADD: begin
                add_req = cut_c[r_q];
                unique case (r_q)
                    2'd0:    add_val = {o_b, o_r, o_t, r_res_r[CW-1:0]};
                    2'd1:    add_val = {o_b, r_res_l, o_t, o_l};
                    2'd2:    add_val = {o_b, o_r, r_res_b[CW-1:0], o_l};
                    default: add_val = {r_res_t, o_r, o_t, o_l};
                endcase
            end
            S_DRD: rd_addr = AW'(r_k + CNTW'(1));
            S_DWR: begin
                dir_we   = 1'b1;
                dir_addr = r_k[AW-1:0];
                dir_data = rdata;
            end
            S_PI: rd_addr = r_i[AW-1:0];
            S_PJ: rd_addr = r_j[AW-1:0];
            default: ;
        endcase
        w_en   = dir_we || (add_req && can_add);
        w_addr = dir_we ? dir_addr : r_cnt[AW-1:0];
        w_data = dir_we ? dir_data : add_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_state <= S_INIT;
            r_ret   <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            if (add_req) begin
                if (can_add) r_cnt <= r_cnt + CNTW'(1);
                else         r_lost <= 1'b1;
            end
            unique case (r_state)
                S_INIT: begin
                    r_cw    <= fit_start(i_cfg.start_w);
                    r_ch    <= fit_start(i_cfg.start_h);
                    r_gw    <= 1'b1;
                    r_cnt   <= CNTW'(1);
                    r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_accept) begin
                        r_w     <= i_req_w;
                        r_h     <= i_req_h;
                        r_lost  <= 1'b0;
                        r_fail  <= 1'b0;
                        r_i     <= '0;
                        r_found <= 1'b0;
                        r_state <= S_SRD;
                    end
                end
                S_SRD: r_state <= (r_i < r_cnt) ? S_SCK : S_SEND;
                S_SCK: begin
                    r_fw    <= rd_r - rd_l;
                    r_fh    <= rd_b - rd_t;
                    r_fit   <= (RW'(rd_r - rd_l) >= RW'(r_w)) &&
                               (RW'(rd_b - rd_t) >= RW'(r_h));
                    r_state <= S_SMUL;
                end
                S_SMUL: begin
                    r_area  <= r_fw * r_fh;
                    r_state <= S_SCMP;
                end
                S_SCMP: begin
                    if (r_fit && (!r_found || r_area < r_best_area)) begin
                        r_found     <= 1'b1;
                        r_best      <= r_i;
                        r_best_area <= r_area;
                    end
                    r_i     <= r_i + CNTW'(1);
                    r_state <= S_SRD;
                end
                S_SEND: r_state <= r_found ? S_PLACE : S_GROW;
                S_GROW: begin
                    if (g_wok) begin
                        r_cw <= g_nw;
                    end else if (g_hok) begin
                        r_ch <= g_nh;
                    end
                    if (g_wok || g_hok) begin
                        r_gw    <= !r_gw;
                        r_i     <= '0;
                        r_state <= S_SRD;
                    end else begin
                        r_fail  <= 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_PLACE: begin
                    r_res_l <= rd_l;
                    r_res_t <= rd_t;
                    r_res_r <= pl_r;
                    r_res_b <= pl_b;
                    r_o     <= rdata;
                    r_i     <= '0;
                    if (i_cfg.fast) r_state <= pl_cut ? S_FADD : S_DONE;
                    else            r_state <= S_CRD;
                end
                S_FADD: r_state <= S_DONE;
                S_CRD: begin
                    if (r_i < r_cnt) begin
                        r_state <= S_CCK;
                    end else begin
                        r_i     <= '0;
                        r_state <= S_PI;
                    end
                end
                S_CCK: begin
                    r_o <= rdata;
                    r_q <= '0;
                    if (ov) begin
                        r_state <= S_CADD;
                    end else begin
                        r_i     <= r_i + CNTW'(1);
                        r_state <= S_CRD;
                    end
                end
                S_CADD: begin
                    r_q <= r_q + 2'd1;
                    if (r_q == 2'd3) begin
                        r_k     <= r_i;
                        r_ret   <= S_CRD;
                        r_state <= S_DRD;
                    end
                end
                S_DRD: begin
                    if (r_k + CNTW'(1) < r_cnt) begin
                        r_state <= S_DWR;
                    end else begin
                        r_cnt   <= r_cnt - CNTW'(1);
                        r_state <= r_ret;
                    end
                end
                S_DWR: begin
                    r_k     <= r_k + CNTW'(1);
                    r_state <= S_DRD;
                end
                S_PI: r_state <= (r_i < r_cnt) ? S_PIL : S_DONE;
                S_PIL: begin
                    r_o     <= rdata;
                    r_j     <= r_i + CNTW'(1);
                    r_state <= S_PJ;
                end
                S_PJ: begin
                    if (r_j < r_cnt) begin
                        r_state <= S_PJC;
                    end else begin
                        r_i     <= r_i + CNTW'(1);
                        r_state <= S_PI;
                    end
                end
                S_PJC: begin
                    priority if (ins_ab) begin
                        r_k     <= r_i;
                        r_ret   <= S_PI;
                        r_state <= S_DRD;
                    end else if (ins_ba) begin
                        r_k     <= r_j;
                        r_ret   <= S_PJ;
                        r_state <= S_DRD;
                    end else begin
                        r_j     <= r_j + CNTW'(1);
                        r_state <= S_PJ;
                    end
                end
                S_DONE: if (i_res_ready) r_state <= S_IDLE;
                default: r_state <= S_INIT;
            endcase
        end
    end

    assign o_idle      = r_state == S_IDLE;
    assign o_res_valid = r_state == S_DONE;
    assign o_status    = r_fail ? raa_pkg::ST_NOROOM : (r_lost ? raa_pkg::ST_LOST : raa_pkg::ST_OK);
    assign o_pos_x     = r_fail ? '0 : raa_pkg::REQ_W'(r_res_l);
    assign o_pos_y     = r_fail ? '0 : raa_pkg::REQ_W'(r_res_t);
    assign o_count     = r_cnt;

endmodule

/* rtl/core/rect_area_allocator_core.sv */
// Per request: a search pass over the free list, repeated after each canvas growth,
//   then the split in fast mode; exact mode adds a cut walk over every entry, with
//   cut pieces added for each overlapped entry and later entries shifted on each removal,
//   and a containment sweep over entry pairs with its shifts; plus the accept and done states.
// Throughput: one request in flight; the free-list memory, one read and one write per
//   cycle, paces it. Reset (synchronous, active low) rewrites the initial canvas entry
//   in the init state; a known-index config write holds tready low (restart, rewrite).
module rect_area_allocator_core #(
    parameter int MAX_FREE_RECTS = raa_pkg::MAX_FREE_RECTS_DEF,
    parameter int COORD_BITS     = raa_pkg::COORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // req_width[15:0], req_height[31:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // status[1:0], pos_x[17:2], pos_y[33:18], zero fill
    input  logic        i_cfg_we,
    input  logic [raa_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [raa_pkg::CFG_W-1:0]     i_cfg_wdata
);

    localparam int CNTW = $clog2(MAX_FREE_RECTS + 1);

    raa_pkg::t_cfg r_cfg;
    logic          r_restart;

    // Config registers; a write to a known index restarts the free list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_w <= raa_pkg::RST_START_W;
            r_cfg.start_h <= raa_pkg::RST_START_H;
            r_cfg.limit_w <= raa_pkg::RST_LIMIT_W;
            r_cfg.limit_h <= raa_pkg::RST_LIMIT_H;
            r_cfg.fast    <= 1'b0;
            r_restart     <= 1'b0;
        end else begin
            r_restart <= 1'b0;
            if (i_cfg_we) begin
                r_restart <= 1'b1;
                unique case (i_cfg_addr)
                    raa_pkg::CFG_START_W: r_cfg.start_w <= i_cfg_wdata;
                    raa_pkg::CFG_START_H: r_cfg.start_h <= i_cfg_wdata;
                    raa_pkg::CFG_LIMIT_W: r_cfg.limit_w <= i_cfg_wdata;
                    raa_pkg::CFG_LIMIT_H: r_cfg.limit_h <= i_cfg_wdata;
                    raa_pkg::CFG_FAST:    r_cfg.fast    <= i_cfg_wdata[0];
                    default:              r_restart     <= 1'b0;
                endcase
            end
        end
    end

    logic            seq_idle, res_valid, res_ready;
    logic [1:0]      res_status;
    logic [15:0]     res_x, res_y;
    logic [CNTW-1:0] free_cnt;

    // Hold the request beat off while a restart is pending
    assign s_axis_tready = seq_idle && !r_restart;

    raa_seq #(
        .MAX_FREE_RECTS (MAX_FREE_RECTS),
        .COORD_BITS     (COORD_BITS),
        .CNTW           (CNTW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_restart   (r_restart),
        .i_accept    (s_axis_tvalid && s_axis_tready),
        .i_req_w     (s_axis_tdata[15:0]),
        .i_req_h     (s_axis_tdata[31:16]),
        .o_idle      (seq_idle),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_status    (res_status),
        .o_pos_x     (res_x),
        .o_pos_y     (res_y),
        .o_count     (free_cnt)
    );

    // Output register: a finished result waits here while the next request runs
    logic        r_ovalid;
    logic [39:0] r_odata;

    assign res_ready = !r_ovalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_ready) begin
            r_ovalid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_odata <= {6'd0, res_y, res_x, res_status};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        free_cnt <= CNTW'(MAX_FREE_RECTS))
        else $error("free list count beyond capacity");

    a_noroom_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] == raa_pkg::ST_NOROOM) |->
        (m_axis_tdata[33:2] == 32'd0))
        else $error("failed request carries a position");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while another is in work");
`endif

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for rect_area_allocator_core: a free-rectangle
// predictor follows every accepted request and each response beat is compared.
// Depends on raa_pkg and the core RTL only.
module testbench;

    localparam int  NRECT = 64;
    localparam int  CMAX  = 65535;
    localparam longint CYCLE_LIMIT = 20_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // req_width[15:0], req_height[31:16]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;         // status[1:0], pos_x[17:2], pos_y[33:18]
    logic        i_cfg_we = 1'b0;
    logic [raa_pkg::CFG_IDX_W-1:0] i_cfg_addr = '0;
    logic [raa_pkg::CFG_W-1:0]     i_cfg_wdata = '0;

    rect_area_allocator_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata)
    );

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
    } t_placement;

    t_placement  placements_due[$];
    int          error_count = 0;
    longint      cycle_count = 0;

    // Free-list mirror: edges held as 32-bit values, as the block's widths allow.
    int unsigned rl[NRECT], rt[NRECT], rr[NRECT], rb[NRECT];
    int unsigned rect_count, canvas_w, canvas_h;
    bit          widen_next, dropped_any;
    int unsigned reg_start_w = 256, reg_start_h = 256;
    int unsigned reg_limit_w = 256, reg_limit_h = 256;
    bit          reg_fast = 1'b0;

    // Sender burst state and receiver stall control.
    int          burst_left = 0;
    int          stall_mode = 0;
    int          hold_off = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic void add_rect(int unsigned l, int unsigned t, int unsigned r,
                                     int unsigned b);
        if (rect_count < NRECT) begin
            rl[rect_count] = l; rt[rect_count] = t;
            rr[rect_count] = r; rb[rect_count] = b;
            rect_count++;
        end else begin
            dropped_any = 1'b1;
        end
    endfunction

    function automatic void del_rect(int unsigned i);
        if (i >= rect_count) return;
        for (int unsigned k = i; k + 1 < rect_count; k++) begin
            rl[k] = rl[k+1]; rt[k] = rt[k+1]; rr[k] = rr[k+1]; rb[k] = rb[k+1];
        end
        rect_count--;
    endfunction

    function automatic int unsigned clamp_start(int unsigned v);
        if (v == 0) return 1;
        return (v > CMAX) ? CMAX : v;
    endfunction

    function automatic void restart_canvas();
        canvas_w = clamp_start(reg_start_w);
        canvas_h = clamp_start(reg_start_h);
        widen_next = 1'b1;
        rect_count = 0;
        add_rect(0, 0, canvas_w, canvas_h);
    endfunction

    function automatic int unsigned doubled(int unsigned v);
        return (v * 2 > CMAX) ? CMAX : v * 2;
    endfunction

    // Grow one dimension in turn; a blocked dimension ends the search.
    function automatic bit grow_canvas();
        int unsigned prev;
        if (widen_next && canvas_w < reg_limit_w && canvas_w < CMAX) begin
            prev = canvas_w;
            canvas_w = doubled(prev);
            if (rect_count == 1 && rl[0] == 0 && rt[0] == 0 && rr[0] == prev &&
                rb[0] == canvas_h)
                rr[0] = canvas_w;
            else
                add_rect(prev, 0, canvas_w, canvas_h);
        end else if (!widen_next && canvas_h < reg_limit_h && canvas_h < CMAX) begin
            prev = canvas_h;
            canvas_h = doubled(prev);
            if (rect_count == 1 && rl[0] == 0 && rt[0] == 0 && rr[0] == canvas_w &&
                rb[0] == prev)
                rb[0] = canvas_h;
            else
                add_rect(0, prev, canvas_w, canvas_h);
        end else begin
            return 1'b0;
        end
        widen_next = !widen_next;
        return 1'b1;
    endfunction

    function automatic bit cut_rect(int unsigned i, int unsigned ql, int unsigned qt,
                                    int unsigned qr, int unsigned qb);
        int unsigned ol, ot, orr, ob;
        ol = rl[i]; ot = rt[i]; orr = rr[i]; ob = rb[i];
        if (!(qr > ol && ql < orr && qb > ot && qt < ob)) return 1'b0;
        if (qr < orr) add_rect(qr, ot, orr, ob);
        if (ql > ol)  add_rect(ol, ot, ql, ob);
        if (qb < ob)  add_rect(ol, qb, orr, ob);
        if (qt > ot)  add_rect(ol, ot, orr, qt);
        return 1'b1;
    endfunction

    function automatic bit rect_within(int unsigned a, int unsigned b);
        return rl[a] >= rl[b] && rt[a] >= rt[b] && rr[a] <= rr[b] && rb[a] <= rb[b];
    endfunction

    function automatic void prune_contained();
        int unsigned i, j;
        bit gone;
        i = 0;
        while (i < rect_count) begin
            gone = 1'b0;
            j = i + 1;
            while (j < rect_count) begin
                if (rect_within(i, j)) begin
                    del_rect(i);
                    gone = 1'b1;
                    break;
                end
                if (rect_within(j, i)) del_rect(j);
                else j++;
            end
            if (!gone) i++;
        end
    endfunction

    // Best-area search with growth, then split or cut the chosen rectangle.
    function automatic t_placement place_request(int unsigned w, int unsigned h);
        t_placement  p;
        int unsigned best, best_area, fw, fh, a, i, ql, qt, qr, qb, sr, sb;
        bit          found;
        best = 0; best_area = 0;
        dropped_any = 1'b0;
        forever begin
            found = 1'b0;
            for (i = 0; i < rect_count; i++) begin
                fw = rr[i] - rl[i];
                fh = rb[i] - rt[i];
                if (fw >= w && fh >= h) begin
                    a = fw * fh;
                    if (!found || a < best_area) begin
                        found = 1'b1; best = i; best_area = a;
                    end
                end
            end
            if (found) break;
            if (!grow_canvas()) begin
                p.status = raa_pkg::ST_NOROOM; p.pos_x = '0; p.pos_y = '0;
                return p;
            end
        end
        ql = rl[best]; qt = rt[best]; qr = ql + w; qb = qt + h;
        if (reg_fast) begin
            rl[best] = qr;
            if ((rb[best] - rt[best]) > 2 * h || h >= canvas_h / 2) begin
                sr = rr[best]; sb = rb[best];
                rb[best] = qb;
                add_rect(ql, qb, sr, sb);
            end
        end else begin
            i = 0;
            while (i < rect_count) begin
                if (cut_rect(i, ql, qt, qr, qb)) del_rect(i);
                else i++;
            end
            prune_contained();
        end
        p.status = dropped_any ? raa_pkg::ST_LOST : raa_pkg::ST_OK;
        p.pos_x = ql[15:0];
        p.pos_y = qt[15:0];
        return p;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // Offer one request beat; hold it until taken, then predict its placement.
    // Called and returning at a falling edge.
    task automatic send_request(input int unsigned w, input int unsigned h);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 7);
            burst_left = $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {h[15:0], w[15:0]};
        do @(posedge i_clk); while (!s_axis_tready);
        placements_due.push_back(place_request(w, h));
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        burst_left = 0;
        while (placements_due.size() != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    // Write one register while idle; a write to a known index restarts the free list.
    task automatic write_reg(input logic [raa_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned val);
        i_cfg_we = 1'b1;
        i_cfg_addr = idx;
        i_cfg_wdata = val[15:0];
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            raa_pkg::CFG_START_W: reg_start_w = val & 16'hFFFF;
            raa_pkg::CFG_START_H: reg_start_h = val & 16'hFFFF;
            raa_pkg::CFG_LIMIT_W: reg_limit_w = val & 16'hFFFF;
            raa_pkg::CFG_LIMIT_H: reg_limit_h = val & 16'hFFFF;
            raa_pkg::CFG_FAST:    reg_fast = val[0];
            default: ;
        endcase
        restart_canvas();
        @(negedge i_clk);
    endtask

    task automatic configure(input int unsigned sw, input int unsigned sh,
                             input int unsigned lw, input int unsigned lh,
                             input bit fast);
        wait_idle();
        write_reg(raa_pkg::CFG_START_W, sw);
        write_reg(raa_pkg::CFG_START_H, sh);
        write_reg(raa_pkg::CFG_LIMIT_W, lw);
        write_reg(raa_pkg::CFG_LIMIT_H, lh);
        write_reg(raa_pkg::CFG_FAST, fast);
    endtask

    // Mostly small sizes so lists fill up; now and then a full-range value.
    function automatic int unsigned pick_size();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 65535);
            1:       return 0;
            2, 3:    return $urandom_range(33, 128);
            default: return $urandom_range(1, 32);
        endcase
    endfunction

    task automatic test_default_canvas();
        // Degenerate, whole-canvas and oversize requests at reset settings.
        send_request(0, 0);
        send_request(256, 256);
        send_request(1, 1);
        send_request(65535, 65535);
        send_request(65535, 0);
        send_request(0, 65535);
    endtask

    task automatic test_growth();
        // Zero start acts as one; grow width then height up to the limits.
        configure(0, 0, 8, 4, 1'b0);
        send_request(3, 1);
        send_request(1, 3);
        send_request(8, 4);
        send_request(9, 1);
        // Width blocked at its limit: the request fails without trying height.
        configure(4, 2, 4, 64, 1'b0);
        send_request(1, 8);
    endtask

    task automatic test_saturation();
        // Doubling saturates at the coordinate maximum.
        configure(40000, 65535, 65535, 65535, 1'b0);
        send_request(65535, 10);
        send_request(25535, 20);
        send_request(65535, 65535);
    endtask

    task automatic test_fast_split();
        configure(64, 64, 128, 128, 1'b1);
        send_request(10, 40);
        send_request(10, 5);
        send_request(64, 64);
        send_request(0, 7);
        send_request(200, 1);
    endtask

    task automatic test_random_phases();
        int unsigned sw, sh;
        for (int ph = 0; ph < 5; ph++) begin
            sw = $urandom_range(16, 256);
            sh = $urandom_range(16, 256);
            configure(sw, sh, sw * $urandom_range(1, 4), sh * $urandom_range(1, 4),
                      $urandom_range(0, 2) == 0);
            stall_mode = ph % 3;
            repeat (14) send_request(pick_size(), pick_size());
        end
    endtask

    task automatic test_backpressure();
        // Hold the response side off while requests keep coming.
        configure(128, 128, 256, 256, 1'b1);
        hold_off = 400;
        repeat (15) send_request(pick_size() % 40, pick_size() % 40);
    endtask

    // Response side: stall on its own pattern; a long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else begin
            case (stall_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ((cycle_count / 5) % 3 != 0);
            endcase
        end
    end

    // Compare each response beat with the oldest predicted placement.
    always @(posedge i_clk) begin
        t_placement want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (placements_due.size() == 0) begin
                report_mismatch("unexpected response beats", 1, 0);
            end else begin
                want = placements_due.pop_front();
                if (m_axis_tdata[1:0] != want.status)
                    report_mismatch("status", m_axis_tdata[1:0], want.status);
                if (m_axis_tdata[17:2] != want.pos_x)
                    report_mismatch("pos_x", m_axis_tdata[17:2], want.pos_x);
                if (m_axis_tdata[33:18] != want.pos_y)
                    report_mismatch("pos_y", m_axis_tdata[33:18], want.pos_y);
            end
        end
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge i_clk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        restart_canvas();
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        @(negedge i_clk);
        test_default_canvas();
        test_growth();
        test_saturation();
        test_fast_split();
        test_random_phases();
        test_backpressure();
        stall_mode = 1;
        wait_idle();
        repeat (50) @(negedge i_clk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

/* files.f */
rtl/core/raa_pkg.sv
rtl/core/raa_mem.sv
rtl/core/raa_seq.sv
rtl/core/rect_area_allocator_core.sv
tb/sv/testbench.sv
